@@ rtl/core/phdp_pkg.sv @@
// ----------------------------------------------------------------------------
// Pinhole projection package
// Shared widths, default parameter values and codes of the projection block.
// ----------------------------------------------------------------------------
package phdp_pkg;

   // Widths of registers, fields and internal products.
   localparam int REG_W     = 32;
   localparam int PROD_W    = 64;
   localparam int PIX_W     = 16;
   localparam int CSR_IDX_W = 3;

   // Defaults for the top-level parameters.
   localparam int FRAC_BITS_DEF  = 16;
   localparam int PIXEL_BITS_DEF = 16;

   typedef enum logic {
      OP_PROJECT     = 1'b0,
      OP_BACKPROJECT = 1'b1
   } op_type;

   typedef enum logic [1:0] {
      STATUS_OK       = 2'd0,
      STATUS_ZERO_DIV = 2'd1,
      STATUS_SAT      = 2'd2
   } status_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_FOCAL_X  = 3'd0,
      CSR_FOCAL_Y  = 3'd1,
      CSR_CENTER_X = 3'd2,
      CSR_CENTER_Y = 3'd3,
      CSR_NORMAL_X = 3'd4,
      CSR_NORMAL_Y = 3'd5,
      CSR_NORMAL_Z = 3'd6
   } csr_index_type;

endpackage

@@ rtl/core/phdp_intf.sv @@
// ----------------------------------------------------------------------------
// Pinhole projection channels
// Request, response and register write channels with valid/ready handshakes.
// ----------------------------------------------------------------------------
interface phdp_req_if;
   logic                                   valid;
   logic                                   ready;
   phdp_pkg::op_type                       op;
   logic signed [phdp_pkg::REG_W-1:0]      pt_x;
   logic signed [phdp_pkg::REG_W-1:0]      pt_y;
   logic signed [phdp_pkg::REG_W-1:0]      pt_z;
   logic signed [phdp_pkg::PIX_W-1:0]      pix_u;
   logic signed [phdp_pkg::PIX_W-1:0]      pix_v;
   logic                                   flip_y;

   modport source (output valid, op, pt_x, pt_y, pt_z, pix_u, pix_v, flip_y, input ready);
   modport sink   (input valid, op, pt_x, pt_y, pt_z, pix_u, pix_v, flip_y, output ready);
endinterface

interface phdp_rsp_if;
   logic                                   valid;
   logic                                   ready;
   logic signed [phdp_pkg::PIX_W-1:0]      out_u;
   logic signed [phdp_pkg::PIX_W-1:0]      out_v;
   logic signed [phdp_pkg::REG_W-1:0]      out_x;
   logic signed [phdp_pkg::REG_W-1:0]      out_y;
   logic signed [phdp_pkg::REG_W-1:0]      out_z;
   phdp_pkg::status_type                   status;

   modport source (output valid, out_u, out_v, out_x, out_y, out_z, status, input ready);
   modport sink   (input valid, out_u, out_v, out_x, out_y, out_z, status, output ready);
endinterface

interface phdp_csr_if;
   logic                                   valid;
   logic                                   ready;
   logic [phdp_pkg::CSR_IDX_W-1:0]         index;
   logic [phdp_pkg::REG_W-1:0]             data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

@@ rtl/core/phdp_div_cell.sv @@
// ----------------------------------------------------------------------------
// Divider cell
// One restoring division step per lane, registered, with side data alongside.
// ----------------------------------------------------------------------------
module phdp_div_cell #(
   parameter int NUM_W  = 64,
   parameter int DEN_W  = 32,
   parameter int LANES  = 2,
   parameter int SIDE_W = 5
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              en,
   input  logic              in_valid,
   input  logic [NUM_W-1:0]  in_acc  [LANES],
   input  logic [DEN_W-1:0]  in_rem  [LANES],
   input  logic [DEN_W-1:0]  in_den  [LANES],
   input  logic [SIDE_W-1:0] in_side,
   output logic              out_valid,
   output logic [NUM_W-1:0]  out_acc [LANES],
   output logic [DEN_W-1:0]  out_rem [LANES],
   output logic [DEN_W-1:0]  out_den [LANES],
   output logic [SIDE_W-1:0] out_side
);

   logic              valid_ff;
   logic [NUM_W-1:0]  acc_ff [LANES];
   logic [DEN_W-1:0]  rem_ff [LANES];
   logic [DEN_W-1:0]  den_ff [LANES];
   logic [SIDE_W-1:0] side_ff;
   logic [NUM_W-1:0]  acc_in [LANES];
   logic [DEN_W-1:0]  rem_in [LANES];

   // The accumulator shifts the dividend out at the top and the quotient in
   // at the bottom, so after NUM_W cells it holds the whole quotient.
   always_comb begin
      logic [DEN_W:0] trial;
      logic [DEN_W:0] diff;
      for (int l = 0; l < LANES; l++) begin
         trial = {in_rem[l], in_acc[l][NUM_W-1]};
         diff  = trial - {1'b0, in_den[l]};
         if (trial >= {1'b0, in_den[l]}) begin
            rem_in[l] = diff[DEN_W-1:0];
            acc_in[l] = {in_acc[l][NUM_W-2:0], 1'b1};
         end else begin
            rem_in[l] = trial[DEN_W-1:0];
            acc_in[l] = {in_acc[l][NUM_W-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         acc_ff  <= acc_in;
         rem_ff  <= rem_in;
         den_ff  <= in_den;
         side_ff <= in_side;
      end
   end

   assign out_valid = valid_ff;
   assign out_acc   = acc_ff;
   assign out_rem   = rem_ff;
   assign out_den   = den_ff;
   assign out_side  = side_ff;

endmodule

@@ rtl/core/phdp_divider.sv @@
// ----------------------------------------------------------------------------
// Divider chain
// A row of divider cells, one quotient bit per cell, one new item per cycle while en is high.
// ----------------------------------------------------------------------------
module phdp_divider #(
   parameter int NUM_W  = 64,
   parameter int DEN_W  = 32,
   parameter int LANES  = 2,
   parameter int SIDE_W = 5
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              en,
   input  logic              in_valid,
   input  logic [NUM_W-1:0]  in_num  [LANES],
   input  logic [DEN_W-1:0]  in_den  [LANES],
   input  logic [SIDE_W-1:0] in_side,
   output logic              out_valid,
   output logic [NUM_W-1:0]  out_quo [LANES],
   output logic [SIDE_W-1:0] out_side
);

   logic              valid_w [NUM_W+1];
   logic [NUM_W-1:0]  acc_w   [NUM_W+1][LANES];
   logic [DEN_W-1:0]  rem_w   [NUM_W+1][LANES];
   logic [DEN_W-1:0]  den_w   [NUM_W+1][LANES];
   logic [SIDE_W-1:0] side_w  [NUM_W+1];

   assign valid_w[0] = in_valid;
   assign acc_w[0]   = in_num;
   assign den_w[0]   = in_den;
   assign side_w[0]  = in_side;

   for (genvar l = 0; l < LANES; l++) begin : g_rem0
      assign rem_w[0][l] = '0;
   end

   for (genvar k = 0; k < NUM_W; k++) begin : g_cell
      phdp_div_cell #(
         .NUM_W  (NUM_W),
         .DEN_W  (DEN_W),
         .LANES  (LANES),
         .SIDE_W (SIDE_W)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .en        (en),
         .in_valid  (valid_w[k]),
         .in_acc    (acc_w[k]),
         .in_rem    (rem_w[k]),
         .in_den    (den_w[k]),
         .in_side   (side_w[k]),
         .out_valid (valid_w[k+1]),
         .out_acc   (acc_w[k+1]),
         .out_rem   (rem_w[k+1]),
         .out_den   (den_w[k+1]),
         .out_side  (side_w[k+1])
      );
   end

   assign out_valid = valid_w[NUM_W];
   assign out_quo   = acc_w[NUM_W];
   assign out_side  = side_w[NUM_W];

endmodule

@@ rtl/core/pinhole_project_deproject_top.sv @@
// ----------------------------------------------------------------------------
// Pinhole projection and ground-plane back-projection
// Projects camera points to pixels or casts pixels back onto a plane.
// ----------------------------------------------------------------------------
// One item enters per cycle unless the pipeline is paused, and its result is
// shown on the response channel once it has passed two chains of divider
// cells, one quotient bit per cell: a 64-cell chain for the projection and ray
// divisions and a (32 + FRAC_BITS)-cell chain for the plane divisions, plus
// eight registers for the input, multiplies, sign handling and output; the
// input register loads on the accepting edge itself.
// When a result is held back on the response channel the whole pipeline pauses;
// the input register still takes an item if it is empty. Register writes are
// taken in any cycle and must only be made while no item is in flight.
module pinhole_project_deproject_top #(
   parameter int FRAC_BITS  = phdp_pkg::FRAC_BITS_DEF,
   parameter int PIXEL_BITS = phdp_pkg::PIXEL_BITS_DEF
) (
   input  logic       clock,
   input  logic       reset,
   phdp_req_if.sink   req_ch,
   phdp_rsp_if.source rsp_ch,
   phdp_csr_if.sink   csr_ch
);

   localparam int RW      = phdp_pkg::REG_W;
   localparam int PW      = phdp_pkg::PROD_W;
   localparam int NB_NUM_W = RW + FRAC_BITS;
   localparam int NB_DEN_W = 2 * RW - FRAC_BITS;
   localparam int D_W      = NB_DEN_W + 1;
   localparam int SIDE_A_W = 5;
   localparam int SIDE_B_W = 6 + 2 * PIXEL_BITS;

   localparam logic [RW-1:0] ONE_Q = RW'(1) << FRAC_BITS;
   localparam logic [PW-1:0] PROJ_LIM = PW'(1) << 60;
   localparam logic [PW-1:0] RAY_LIM_NEG = PW'(1) << (RW - 1);
   localparam logic [PW-1:0] RAY_LIM_POS = RAY_LIM_NEG - PW'(1);
   localparam logic signed [PW-1:0] PIX_MAX = (PW'(1) << (PIXEL_BITS - 1)) - PW'(1);
   localparam logic signed [PW-1:0] PIX_MIN = -(PW'(1) << (PIXEL_BITS - 1));
   localparam logic [NB_NUM_W-1:0] OUT_LIM_NEG = NB_NUM_W'(1) << (RW - 1);
   localparam logic [NB_NUM_W-1:0] OUT_LIM_POS = OUT_LIM_NEG - NB_NUM_W'(1);
   localparam logic [NB_NUM_W-1:0] ONE_SQ = NB_NUM_W'(1) << (2 * FRAC_BITS);

   // Signed division by 2^FRAC_BITS, rounding toward zero.
   function automatic logic [PW-1:0] shr_trunc(input logic [PW-1:0] val);
      logic [PW-1:0] mag;
      logic [PW-1:0] sh;
      mag = val[PW-1] ? (~val + PW'(1)) : val;
      sh  = mag >> FRAC_BITS;
      return val[PW-1] ? (~sh + PW'(1)) : sh;
   endfunction

   logic en;

   // ---------------- configuration registers ----------------
   logic [RW-1:0] fx_ff, fy_ff, cx_ff, cy_ff, nx_ff, ny_ff, nz_ff;
   logic [RW-1:0] fx_in, fy_in, cx_in, cy_in, nx_in, ny_in, nz_in;

   assign csr_ch.ready = 1'b1;

   always_comb begin
      fx_in = fx_ff;
      fy_in = fy_ff;
      cx_in = cx_ff;
      cy_in = cy_ff;
      nx_in = nx_ff;
      ny_in = ny_ff;
      nz_in = nz_ff;
      if (csr_ch.valid) begin
         case (phdp_pkg::csr_index_type'(csr_ch.index))
            phdp_pkg::CSR_FOCAL_X:  fx_in = csr_ch.data;
            phdp_pkg::CSR_FOCAL_Y:  fy_in = csr_ch.data;
            phdp_pkg::CSR_CENTER_X: cx_in = csr_ch.data;
            phdp_pkg::CSR_CENTER_Y: cy_in = csr_ch.data;
            phdp_pkg::CSR_NORMAL_X: nx_in = csr_ch.data;
            phdp_pkg::CSR_NORMAL_Y: ny_in = csr_ch.data;
            phdp_pkg::CSR_NORMAL_Z: nz_in = csr_ch.data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fx_ff <= ONE_Q;
         fy_ff <= ONE_Q;
         cx_ff <= '0;
         cy_ff <= '0;
         nx_ff <= '0;
         ny_ff <= '0;
         nz_ff <= ONE_Q;
      end else begin
         fx_ff <= fx_in;
         fy_ff <= fy_in;
         cx_ff <= cx_in;
         cy_ff <= cy_in;
         nx_ff <= nx_in;
         ny_ff <= ny_in;
         nz_ff <= nz_in;
      end
   end

   // ---------------- stage 0: input register ----------------
   logic                  s0_valid_ff, s0_valid_in, s0_load;
   phdp_pkg::op_type      s0_op_ff;
   logic signed [RW-1:0]  s0_pt_x_ff, s0_pt_y_ff, s0_pt_z_ff;
   logic signed [phdp_pkg::PIX_W-1:0] s0_pix_u_ff, s0_pix_v_ff;
   logic                  s0_flip_ff;

   assign s0_load      = en || !s0_valid_ff;
   assign req_ch.ready = s0_load;
   assign s0_valid_in  = s0_load ? req_ch.valid : s0_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff <= 1'b0;
      end else begin
         s0_valid_ff <= s0_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s0_load) begin
         s0_op_ff    <= req_ch.op;
         s0_pt_x_ff  <= req_ch.pt_x;
         s0_pt_y_ff  <= req_ch.pt_y;
         s0_pt_z_ff  <= req_ch.pt_z;
         s0_pix_u_ff <= req_ch.pix_u;
         s0_pix_v_ff <= req_ch.pix_v;
         s0_flip_ff  <= req_ch.flip_y;
      end
   end

   // ---------------- stage 1: products or ray numerators ----------------
   logic             s1_valid_ff;
   phdp_pkg::op_type s1_op_ff;
   logic             s1_flip_ff, s1_zero_ff, s1_zero_in;
   logic [PW-1:0]    s1_lane_ff [2];
   logic [PW-1:0]    s1_lane_in [2];
   logic [RW:0]      s1_den_ff [2];
   logic [RW:0]      s1_den_in [2];

   always_comb begin
      logic [PW-1:0] prod_u, prod_v, ray_u, ray_v;
      prod_u = $signed({1'b0, fx_ff}) * s0_pt_x_ff;
      prod_v = $signed({1'b0, fy_ff}) * s0_pt_y_ff;
      ray_u  = ({{(PW - phdp_pkg::PIX_W){s0_pix_u_ff[phdp_pkg::PIX_W-1]}}, s0_pix_u_ff}
                << FRAC_BITS) - {{RW{1'b0}}, cx_ff};
      ray_v  = ({{(PW - phdp_pkg::PIX_W){s0_pix_v_ff[phdp_pkg::PIX_W-1]}}, s0_pix_v_ff}
                << FRAC_BITS) - {{RW{1'b0}}, cy_ff};
      if (s0_op_ff == phdp_pkg::OP_BACKPROJECT) begin
         s1_lane_in[0] = ray_u;
         s1_lane_in[1] = ray_v;
         s1_den_in[0]  = {1'b0, fx_ff};
         s1_den_in[1]  = {1'b0, fy_ff};
         s1_zero_in    = (fx_ff == '0) || (fy_ff == '0);
      end else begin
         s1_lane_in[0] = prod_u;
         s1_lane_in[1] = prod_v;
         s1_den_in[0]  = {s0_pt_z_ff[RW-1], s0_pt_z_ff};
         s1_den_in[1]  = {s0_pt_z_ff[RW-1], s0_pt_z_ff};
         s1_zero_in    = (s0_pt_z_ff == '0);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (en) begin
         s1_valid_ff <= s0_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s1_op_ff   <= s0_op_ff;
         s1_flip_ff <= s0_flip_ff;
         s1_zero_ff <= s1_zero_in;
         s1_lane_ff <= s1_lane_in;
         s1_den_ff  <= s1_den_in;
      end
   end

   // ---------------- stage 2: magnitudes into the first divider ----------------
   logic             s2_valid_ff;
   phdp_pkg::op_type s2_op_ff;
   logic             s2_flip_ff, s2_zero_ff;
   logic [1:0]       s2_sign_ff, s2_sign_in;
   logic [PW-1:0]    s2_num_ff [2];
   logic [PW-1:0]    s2_num_in [2];
   logic [RW-1:0]    s2_den_ff [2];
   logic [RW-1:0]    s2_den_in [2];

   always_comb begin
      logic [PW-1:0] mag;
      logic [RW:0]   dabs;
      for (int l = 0; l < 2; l++) begin
         mag  = s1_lane_ff[l][PW-1] ? (~s1_lane_ff[l] + PW'(1)) : s1_lane_ff[l];
         dabs = s1_den_ff[l][RW] ? (~s1_den_ff[l] + (RW+1)'(1)) : s1_den_ff[l];
         s2_sign_in[l] = s1_lane_ff[l][PW-1] ^ s1_den_ff[l][RW];
         s2_den_in[l]  = dabs[RW-1:0];
         s2_num_in[l]  = (s1_op_ff == phdp_pkg::OP_BACKPROJECT) ? (mag << FRAC_BITS) : mag;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (en) begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s2_op_ff   <= s1_op_ff;
         s2_flip_ff <= s1_flip_ff;
         s2_zero_ff <= s1_zero_ff;
         s2_sign_ff <= s2_sign_in;
         s2_num_ff  <= s2_num_in;
         s2_den_ff  <= s2_den_in;
      end
   end

   // ---------------- first divider chain ----------------
   logic                da_valid;
   logic [PW-1:0]       da_quo [2];
   logic [SIDE_A_W-1:0] da_side;

   phdp_divider #(
      .NUM_W  (PW),
      .DEN_W  (RW),
      .LANES  (2),
      .SIDE_W (SIDE_A_W)
   ) u_div_a (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (s2_valid_ff),
      .in_num    (s2_num_ff),
      .in_den    (s2_den_ff),
      .in_side   ({s2_op_ff, s2_flip_ff, s2_zero_ff, s2_sign_ff}),
      .out_valid (da_valid),
      .out_quo   (da_quo),
      .out_side  (da_side)
   );

   phdp_pkg::op_type da_op;
   logic             da_flip, da_zero;
   logic [1:0]       da_sign;

   assign da_op   = phdp_pkg::op_type'(da_side[4]);
   assign da_flip = da_side[3];
   assign da_zero = da_side[2];
   assign da_sign = da_side[1:0];

   // ---------------- stage 3: clamp quotients ----------------
   logic             s3_valid_ff;
   phdp_pkg::op_type s3_op_ff;
   logic             s3_flip_ff, s3_zero_ff, s3_sat_ff, s3_sat_in;
   logic [PW-1:0]    s3_val_ff [2];
   logic [PW-1:0]    s3_val_in [2];

   always_comb begin
      logic [PW-1:0] lim;
      logic [PW-1:0] mag;
      logic [PW-1:0] cen;
      logic          over;
      s3_sat_in = 1'b0;
      for (int l = 0; l < 2; l++) begin
         cen = (l == 0) ? {{RW{1'b0}}, cx_ff} : {{RW{1'b0}}, cy_ff};
         if (da_op == phdp_pkg::OP_BACKPROJECT) begin
            lim = da_sign[l] ? RAY_LIM_NEG : RAY_LIM_POS;
         end else begin
            lim = PROJ_LIM;
         end
         over = da_quo[l] > lim;
         mag  = over ? lim : da_quo[l];
         s3_sat_in = s3_sat_in | over;
         if (da_op == phdp_pkg::OP_BACKPROJECT) begin
            s3_val_in[l] = da_sign[l] ? (~mag + PW'(1)) : mag;
         end else begin
            s3_val_in[l] = (da_sign[l] ? (~mag + PW'(1)) : mag) + cen;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else if (en) begin
         s3_valid_ff <= da_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s3_op_ff   <= da_op;
         s3_flip_ff <= da_flip;
         s3_zero_ff <= da_zero;
         s3_sat_ff  <= s3_sat_in;
         s3_val_ff  <= s3_val_in;
      end
   end

   // ---------------- stage 4: pixel clamp or plane products ----------------
   logic                  s4_valid_ff;
   phdp_pkg::op_type      s4_op_ff;
   logic                  s4_flip_ff, s4_zero_ff, s4_sat_ff, s4_sat_in;
   logic [PW-1:0]         s4_prod_ff [2];
   logic [PW-1:0]         s4_prod_in [2];
   logic [RW-1:0]         s4_ray_ff [2];
   logic [PIXEL_BITS-1:0] s4_pix_ff [2];
   logic [PIXEL_BITS-1:0] s4_pix_in [2];

   always_comb begin
      logic [PW-1:0] t;
      logic [RW-1:0] nrm;
      logic          clip;
      s4_sat_in = s3_sat_ff;
      for (int l = 0; l < 2; l++) begin
         t    = shr_trunc(s3_val_ff[l]);
         clip = 1'b0;
         if ($signed(t) > PIX_MAX) begin
            s4_pix_in[l] = PIX_MAX[PIXEL_BITS-1:0];
            clip         = 1'b1;
         end else if ($signed(t) < PIX_MIN) begin
            s4_pix_in[l] = PIX_MIN[PIXEL_BITS-1:0];
            clip         = 1'b1;
         end else begin
            s4_pix_in[l] = t[PIXEL_BITS-1:0];
         end
         if (s3_op_ff == phdp_pkg::OP_PROJECT) begin
            s4_sat_in = s4_sat_in | clip;
         end
         // A ray component always fits in 32 signed bits after its clamp.
         nrm = (l == 0) ? nx_ff : ny_ff;
         s4_prod_in[l] = $signed(nrm) * $signed(s3_val_ff[l][RW-1:0]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s4_valid_ff <= 1'b0;
      end else if (en) begin
         s4_valid_ff <= s3_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s4_op_ff     <= s3_op_ff;
         s4_flip_ff   <= s3_flip_ff;
         s4_zero_ff   <= s3_zero_ff;
         s4_sat_ff    <= s4_sat_in;
         s4_prod_ff   <= s4_prod_in;
         s4_ray_ff[0] <= s3_val_ff[0][RW-1:0];
         s4_ray_ff[1] <= s3_val_ff[1][RW-1:0];
         s4_pix_ff    <= s4_pix_in;
      end
   end

   // ---------------- stage 5: plane divisor ----------------
   logic                  s5_valid_ff;
   phdp_pkg::op_type      s5_op_ff;
   logic                  s5_flip_ff, s5_zero_ff, s5_sat_ff;
   logic [D_W-1:0]        s5_d_ff, s5_d_in;
   logic [RW-1:0]         s5_ray_ff [2];
   logic [PIXEL_BITS-1:0] s5_pix_ff [2];

   always_comb begin
      logic [PW-1:0] dsum;
      dsum    = shr_trunc(s4_prod_ff[0]) + shr_trunc(s4_prod_ff[1])
              + {{RW{nz_ff[RW-1]}}, nz_ff};
      s5_d_in = dsum[D_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s5_valid_ff <= 1'b0;
      end else if (en) begin
         s5_valid_ff <= s4_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s5_op_ff   <= s4_op_ff;
         s5_flip_ff <= s4_flip_ff;
         s5_zero_ff <= s4_zero_ff;
         s5_sat_ff  <= s4_sat_ff;
         s5_d_ff    <= s5_d_in;
         s5_ray_ff  <= s4_ray_ff;
         s5_pix_ff  <= s4_pix_ff;
      end
   end

   // ---------------- stage 6: operands of the plane divisions ----------------
   logic                  s6_valid_ff;
   phdp_pkg::op_type      s6_op_ff;
   logic                  s6_zero_ff, s6_zero_in, s6_sat_ff;
   logic [2:0]            s6_sign_ff, s6_sign_in;
   logic [NB_NUM_W-1:0]   s6_num_ff [3];
   logic [NB_NUM_W-1:0]   s6_num_in [3];
   logic [NB_DEN_W-1:0]   s6_den_ff [3];
   logic [NB_DEN_W-1:0]   s6_den_in [3];
   logic [PIXEL_BITS-1:0] s6_pix_ff [2];

   always_comb begin
      logic [D_W-1:0] dabs;
      logic           dneg;
      logic [RW-1:0]  rabs;
      dneg = s5_d_ff[D_W-1];
      dabs = dneg ? (~s5_d_ff + D_W'(1)) : s5_d_ff;
      for (int l = 0; l < 3; l++) begin
         s6_den_in[l] = dabs[NB_DEN_W-1:0];
      end
      s6_num_in[0]  = ONE_SQ;
      s6_sign_in[0] = dneg;
      for (int l = 0; l < 2; l++) begin
         rabs = s5_ray_ff[l][RW-1] ? (~s5_ray_ff[l] + RW'(1)) : s5_ray_ff[l];
         s6_num_in[l+1]  = NB_NUM_W'(rabs) << FRAC_BITS;
         s6_sign_in[l+1] = s5_ray_ff[l][RW-1] ^ dneg;
      end
      // A flipped y only changes the sign of its quotient.
      s6_sign_in[1] = s6_sign_in[1] ^ s5_flip_ff;
      s6_zero_in = s5_zero_ff ||
                   ((s5_op_ff == phdp_pkg::OP_BACKPROJECT) && (s5_d_ff == '0));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s6_valid_ff <= 1'b0;
      end else if (en) begin
         s6_valid_ff <= s5_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s6_op_ff   <= s5_op_ff;
         s6_zero_ff <= s6_zero_in;
         s6_sat_ff  <= s5_sat_ff;
         s6_sign_ff <= s6_sign_in;
         s6_num_ff  <= s6_num_in;
         s6_den_ff  <= s6_den_in;
         s6_pix_ff  <= s5_pix_ff;
      end
   end

   // ---------------- second divider chain ----------------
   logic                db_valid;
   logic [NB_NUM_W-1:0] db_quo [3];
   logic [SIDE_B_W-1:0] db_side;

   phdp_divider #(
      .NUM_W  (NB_NUM_W),
      .DEN_W  (NB_DEN_W),
      .LANES  (3),
      .SIDE_W (SIDE_B_W)
   ) u_div_b (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (s6_valid_ff),
      .in_num    (s6_num_ff),
      .in_den    (s6_den_ff),
      .in_side   ({s6_op_ff, s6_zero_ff, s6_sat_ff, s6_sign_ff, s6_pix_ff[1], s6_pix_ff[0]}),
      .out_valid (db_valid),
      .out_quo   (db_quo),
      .out_side  (db_side)
   );

   phdp_pkg::op_type      db_op;
   logic                  db_zero, db_sat;
   logic [2:0]            db_sign;
   logic [PIXEL_BITS-1:0] db_pix_u, db_pix_v;

   assign db_op    = phdp_pkg::op_type'(db_side[SIDE_B_W-1]);
   assign db_zero  = db_side[SIDE_B_W-2];
   assign db_sat   = db_side[SIDE_B_W-3];
   assign db_sign  = db_side[2*PIXEL_BITS+2:2*PIXEL_BITS];
   assign db_pix_v = db_side[2*PIXEL_BITS-1:PIXEL_BITS];
   assign db_pix_u = db_side[PIXEL_BITS-1:0];

   // ---------------- output register ----------------
   logic                            rsp_valid_ff;
   logic [phdp_pkg::PIX_W-1:0]      out_u_ff, out_v_ff, out_u_in, out_v_in;
   logic [RW-1:0]                   out_xyz_ff [3];
   logic [RW-1:0]                   out_xyz_in [3];
   phdp_pkg::status_type            status_ff, status_in;

   assign en = !rsp_valid_ff || rsp_ch.ready;

   always_comb begin
      logic [RW-1:0] pu_ext, pv_ext;
      logic          over;
      logic          sat_out;
      logic [RW-1:0] val [3];
      sat_out = 1'b0;
      for (int l = 0; l < 3; l++) begin
         if (db_sign[l]) begin
            over   = db_quo[l] > OUT_LIM_NEG;
            val[l] = over ? OUT_LIM_NEG[RW-1:0] : (~db_quo[l][RW-1:0] + RW'(1));
         end else begin
            over   = db_quo[l] > OUT_LIM_POS;
            val[l] = over ? OUT_LIM_POS[RW-1:0] : db_quo[l][RW-1:0];
         end
         sat_out = sat_out | over;
      end
      pu_ext = {{(RW - PIXEL_BITS){db_pix_u[PIXEL_BITS-1]}}, db_pix_u};
      pv_ext = {{(RW - PIXEL_BITS){db_pix_v[PIXEL_BITS-1]}}, db_pix_v};

      out_u_in = '0;
      out_v_in = '0;
      for (int l = 0; l < 3; l++) begin
         out_xyz_in[l] = '0;
      end
      if (db_zero) begin
         status_in = phdp_pkg::STATUS_ZERO_DIV;
      end else if (db_op == phdp_pkg::OP_BACKPROJECT) begin
         out_xyz_in = val;
         status_in  = (db_sat || sat_out) ? phdp_pkg::STATUS_SAT : phdp_pkg::STATUS_OK;
      end else begin
         out_u_in  = pu_ext[phdp_pkg::PIX_W-1:0];
         out_v_in  = pv_ext[phdp_pkg::PIX_W-1:0];
         status_in = db_sat ? phdp_pkg::STATUS_SAT : phdp_pkg::STATUS_OK;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= db_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         out_u_ff   <= out_u_in;
         out_v_ff   <= out_v_in;
         out_xyz_ff <= out_xyz_in;
         status_ff  <= status_in;
      end
   end

   assign rsp_ch.valid  = rsp_valid_ff;
   assign rsp_ch.out_u  = out_u_ff;
   assign rsp_ch.out_v  = out_v_ff;
   assign rsp_ch.out_x  = out_xyz_ff[0];
   assign rsp_ch.out_y  = out_xyz_ff[1];
   assign rsp_ch.out_z  = out_xyz_ff[2];
   assign rsp_ch.status = status_ff;

endmodule

@@ rtl/core/phdp_checker.sv @@
// ----------------------------------------------------------------------------
// Pinhole projection checker
// Port-level checks on the projection block, bound to its top level.
// ----------------------------------------------------------------------------
module phdp_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_valid,
   input logic                              req_ready,
   input logic                              rsp_valid,
   input logic                              rsp_ready,
   input logic [phdp_pkg::PIX_W-1:0]        out_u,
   input logic [phdp_pkg::PIX_W-1:0]        out_v,
   input logic [phdp_pkg::REG_W-1:0]        out_x,
   input logic [phdp_pkg::REG_W-1:0]        out_y,
   input logic [phdp_pkg::REG_W-1:0]        out_z,
   input phdp_pkg::status_type              status
);

   // Reset empties the pipeline, so no result shows in the following cycle.
   a_reset_empties: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result shown straight after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(out_u) && $stable(out_v) &&
      $stable(out_x) && $stable(out_y) && $stable(out_z) && $stable(status))
      else $error("stalled result changed");

   // Input is refused only while a finished result is held back.
   a_ready_cause: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid && !rsp_ready)
      else $error("input refused without output back-pressure");

   a_zero_div_clear: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && status == phdp_pkg::STATUS_ZERO_DIV |->
      out_u == '0 && out_v == '0 && out_x == '0 && out_y == '0 && out_z == '0)
      else $error("zero divisor result carries data");

   // A pixel result never carries plane coordinates.
   a_pixel_only: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (out_u != '0 || out_v != '0) |->
      out_x == '0 && out_y == '0 && out_z == '0)
      else $error("pixel and plane fields both set");

endmodule

bind pinhole_project_deproject_top phdp_checker u_phdp_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_ch.valid),
   .req_ready (req_ch.ready),
   .rsp_valid (rsp_ch.valid),
   .rsp_ready (rsp_ch.ready),
   .out_u     (rsp_ch.out_u),
   .out_v     (rsp_ch.out_v),
   .out_x     (rsp_ch.out_x),
   .out_y     (rsp_ch.out_y),
   .out_z     (rsp_ch.out_z),
   .status    (rsp_ch.status)
);

@@ test/tb_top.sv @@
// ----------------------------------------------------------------------------
// Pinhole projection testbench
// Sends projection and back-projection items under several camera and plane
// settings. Every result is checked against a predictor held in this module.
// ----------------------------------------------------------------------------
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int  LATENCY     = 120;
   localparam int  CYCLE_LIMIT = 400000;
   localparam longint ONE      = 64'sd65536;

   typedef struct {
      phdp_pkg::op_type   op;
      logic signed [31:0] pt_x, pt_y, pt_z;
      logic signed [15:0] pix_u, pix_v;
      logic               flip_y;
   } cam_item_type;

   typedef struct {
      logic signed [15:0]   out_u, out_v;
      logic signed [31:0]   out_x, out_y, out_z;
      phdp_pkg::status_type status;
   } cam_result_type;

   logic clock;
   logic reset;

   phdp_req_if req ();
   phdp_rsp_if rsp ();
   phdp_csr_if csr ();

   pinhole_project_deproject_top uut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req),
      .rsp_ch (rsp),
      .csr_ch (csr)
   );

   // Shadow copy of the camera and plane registers.
   logic [31:0] cam_regs [0:6];

   cam_result_type pending_results [$];
   int          error_count;
   int          checked_count;
   int          sent_count;
   int          burst_left;
   longint      cycle_count;

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // ------------------------------------------------------------ predictor --
   function automatic longint clamp_range(longint v, longint lo, longint hi, inout bit sat);
      if (v < lo) begin
         sat = 1'b1;
         return lo;
      end
      if (v > hi) begin
         sat = 1'b1;
         return hi;
      end
      return v;
   endfunction

   function automatic longint project_axis(logic [31:0] f, logic signed [31:0] p,
                                           logic signed [31:0] den, logic [31:0] c,
                                           inout bit sat);
      longint q;
      q = (longint'({32'b0, f}) * longint'(p)) / longint'(den);
      q = clamp_range(q, -(64'sd1 <<< 60), 64'sd1 <<< 60, sat);
      q = (q + longint'({32'b0, c})) / ONE;
      return clamp_range(q, -64'sd32768, 64'sd32767, sat);
   endfunction

   function automatic longint ray_component(logic signed [15:0] pix, logic [31:0] c,
                                            logic [31:0] f, inout bit sat);
      longint      num;
      bit          neg;
      logic [63:0] mag;
      logic [63:0] q;
      longint      v;
      num = longint'(pix) * ONE - longint'({32'b0, c});
      neg = num < 0;
      mag = neg ? -num : num;
      q   = (mag << 16) / {32'b0, f};
      if (q > (64'd1 << 32)) q = 64'd1 << 32;
      v = neg ? -longint'(q) : longint'(q);
      return clamp_range(v, -64'sd2147483648, 64'sd2147483647, sat);
   endfunction

   function automatic cam_result_type predict_result(cam_item_type it);
      cam_result_type r;
      bit          sat;
      longint      u, v, ox, oy, oz, r0, r1, d;
      sat = 1'b0;
      u = 0; v = 0; ox = 0; oy = 0; oz = 0;
      r.status = phdp_pkg::STATUS_OK;
      if (it.op == phdp_pkg::OP_PROJECT) begin
         if (it.pt_z == 0) begin
            r.status = phdp_pkg::STATUS_ZERO_DIV;
         end else begin
            u = project_axis(cam_regs[phdp_pkg::CSR_FOCAL_X], it.pt_x, it.pt_z,
                             cam_regs[phdp_pkg::CSR_CENTER_X], sat);
            v = project_axis(cam_regs[phdp_pkg::CSR_FOCAL_Y], it.pt_y, it.pt_z,
                             cam_regs[phdp_pkg::CSR_CENTER_Y], sat);
         end
      end else if (cam_regs[phdp_pkg::CSR_FOCAL_X] == 0 ||
                   cam_regs[phdp_pkg::CSR_FOCAL_Y] == 0) begin
         r.status = phdp_pkg::STATUS_ZERO_DIV;
      end else begin
         r0 = ray_component(it.pix_u, cam_regs[phdp_pkg::CSR_CENTER_X],
                            cam_regs[phdp_pkg::CSR_FOCAL_X], sat);
         r1 = ray_component(it.pix_v, cam_regs[phdp_pkg::CSR_CENTER_Y],
                            cam_regs[phdp_pkg::CSR_FOCAL_Y], sat);
         d  = (longint'($signed(cam_regs[phdp_pkg::CSR_NORMAL_X])) * r0) / ONE
            + (longint'($signed(cam_regs[phdp_pkg::CSR_NORMAL_Y])) * r1) / ONE
            + longint'($signed(cam_regs[phdp_pkg::CSR_NORMAL_Z]));
         if (d == 0) begin
            r.status = phdp_pkg::STATUS_ZERO_DIV;
            sat = 1'b0;
         end else begin
            ox = (ONE * ONE) / d;
            oy = (r0 * ONE) / d;
            oz = (r1 * ONE) / d;
            if (it.flip_y) oy = -oy;
            ox = clamp_range(ox, -64'sd2147483648, 64'sd2147483647, sat);
            oy = clamp_range(oy, -64'sd2147483648, 64'sd2147483647, sat);
            oz = clamp_range(oz, -64'sd2147483648, 64'sd2147483647, sat);
         end
      end
      if (r.status == phdp_pkg::STATUS_OK && sat) r.status = phdp_pkg::STATUS_SAT;
      r.out_u = u[15:0];
      r.out_v = v[15:0];
      r.out_x = ox[31:0];
      r.out_y = oy[31:0];
      r.out_z = oz[31:0];
      return r;
   endfunction

   // ------------------------------------------------------------- drivers --
   task automatic send_item(cam_item_type it);
      @(negedge clock);
      if (burst_left == 0) begin
         req.valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(negedge clock);
         burst_left = ($urandom_range(0, 3) == 0) ? 60 : $urandom_range(1, 12);
      end
      burst_left--;
      req.valid  <= 1'b1;
      req.op     <= it.op;
      req.pt_x   <= it.pt_x;
      req.pt_y   <= it.pt_y;
      req.pt_z   <= it.pt_z;
      req.pix_u  <= it.pix_u;
      req.pix_v  <= it.pix_v;
      req.flip_y <= it.flip_y;
      do @(posedge clock); while (!req.ready);
      pending_results.push_back(predict_result(it));
      sent_count++;
   endtask

   task automatic write_reg(phdp_pkg::csr_index_type idx, logic [31:0] value);
      @(negedge clock);
      csr.valid <= 1'b1;
      csr.index <= idx;
      csr.data  <= value;
      do @(posedge clock); while (!csr.ready);
      cam_regs[idx] = value;
      @(negedge clock);
      csr.valid <= 1'b0;
   endtask

   task automatic wait_drained();
      @(negedge clock);
      req.valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
   endtask

   task automatic load_camera(logic [31:0] fx, logic [31:0] fy, logic [31:0] cx,
                              logic [31:0] cy, logic [31:0] nx, logic [31:0] ny,
                              logic [31:0] nz);
      wait_drained();
      write_reg(phdp_pkg::CSR_FOCAL_X, fx);
      write_reg(phdp_pkg::CSR_FOCAL_Y, fy);
      write_reg(phdp_pkg::CSR_CENTER_X, cx);
      write_reg(phdp_pkg::CSR_CENTER_Y, cy);
      write_reg(phdp_pkg::CSR_NORMAL_X, nx);
      write_reg(phdp_pkg::CSR_NORMAL_Y, ny);
      write_reg(phdp_pkg::CSR_NORMAL_Z, nz);
   endtask

   function automatic cam_item_type make_project(int x, int y, int z);
      cam_item_type it;
      it = '{op: phdp_pkg::OP_PROJECT, pt_x: x, pt_y: y, pt_z: z,
             pix_u: 16'($urandom), pix_v: 16'($urandom),
             flip_y: $urandom_range(0, 1)};
      return it;
   endfunction

   function automatic cam_item_type make_backproject(int u, int v, bit flip);
      cam_item_type it;
      it = '{op: phdp_pkg::OP_BACKPROJECT, pt_x: $urandom, pt_y: $urandom, pt_z: $urandom,
             pix_u: 16'(u), pix_v: 16'(v), flip_y: flip};
      return it;
   endfunction

   // Mostly moderate coordinates, so that results land inside the image.
   function automatic logic [31:0] rand_coord();
      case ($urandom_range(0, 3))
         0:       return $urandom;
         1:       return $urandom_range(0, 20) - 10;
         default: return $signed($urandom_range(0, 32'h00FF_FFFF)) - 32'sh0080_0000;
      endcase
   endfunction

   function automatic cam_item_type rand_item();
      logic [31:0] z;
      if ($urandom_range(0, 1)) begin
         case ($urandom_range(0, 9))
            0:       z = 0;
            1, 2:    z = $urandom;
            default: z = $urandom_range(32'h0000_4000, 32'h0080_0000);
         endcase
         return make_project(rand_coord(), rand_coord(), z);
      end
      if ($urandom_range(0, 2) == 0)
         return make_backproject($urandom, $urandom, $urandom_range(0, 1));
      return make_backproject($urandom_range(0, 2000) - 1000, $urandom_range(0, 2000) - 1000,
                              $urandom_range(0, 1));
   endfunction

   task automatic send_random(int count);
      for (int n = 0; n < count; n++) send_item(rand_item());
   endtask

   // --------------------------------------------------------------- tests --
   task automatic test_directed_defaults();
      // Reset settings: unit focal lengths, zero centre, plane normal along z.
      send_item(make_project(32'h0001_0000, 32'h0002_0000, 32'h0001_0000));
      send_item(make_project(32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0001));
      send_item(make_project(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000));
      send_item(make_project(32'h0005_0000, 32'hFFFB_0000, 32'h0000_0000));
      send_item(make_project(32'hFFFF_8000, 32'h0000_8000, 32'h7FFF_FFFF));
      send_item(make_project(32'hFFFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF));
      send_item(make_backproject(16'sd0, 16'sd0, 1'b0));
      send_item(make_backproject(16'sd5, -16'sd7, 1'b1));
      send_item(make_backproject(16'sh7FFF, 16'sh8000, 1'b0));
      send_item(make_backproject(16'sh8000, 16'sh7FFF, 1'b1));
      send_item(make_backproject(-16'sd1, 16'sd1, 1'b1));
   endtask

   task automatic test_directed_special();
      // A plane normal that makes the divisor vanish for the centre pixel.
      load_camera(32'h01F4_0000, 32'h01F4_0000, 32'h0140_0000, 32'h00F0_0000,
                  32'h0000_0000, 32'h0001_0000, 32'h0000_0000);
      send_item(make_backproject(16'sd320, 16'sd240, 1'b0));
      send_item(make_backproject(16'sd320, 16'sd300, 1'b1));
      send_item(make_backproject(16'sd100, 16'sd241, 1'b0));
      send_item(make_project(32'h0010_0000, 32'hFFF0_0000, 32'h0020_0000));
      // Zero focal lengths give a zero divisor on back-projection.
      load_camera(32'h0000_0000, 32'h0001_0000, 32'h0000_0000, 32'h0000_0000,
                  32'h0000_0000, 32'h0000_0000, 32'h0001_0000);
      send_item(make_backproject(16'sd10, 16'sd10, 1'b0));
      send_item(make_project(32'h0010_0000, 32'h0010_0000, 32'h0001_0000));
      load_camera(32'h0001_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000,
                  32'h0000_0000, 32'h0000_0000, 32'h0001_0000);
      send_item(make_backproject(16'sd10, 16'sd10, 1'b1));
      // Tiny focal lengths make the ray components saturate.
      load_camera(32'h0000_0001, 32'h0000_0001, 32'hFFFF_FFFF, 32'h0000_0000,
                  32'h0000_0001, 32'h0000_0001, 32'h0000_0001);
      send_item(make_backproject(16'sh7FFF, 16'sh8000, 1'b1));
      send_item(make_backproject(16'sd0, 16'sd0, 1'b0));
      send_item(make_project(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h0000_0001));
   endtask

   task automatic test_random_camera();
      load_camera(32'h01F4_0000, 32'h01F0_8000, 32'h0140_0000, 32'h00F0_0000,
                  32'h0000_0000, 32'h0001_0000, 32'h0000_0000);
      send_random(300);
      // Hold the sender until the pipeline is empty, then carry on.
      wait_drained();
      send_random(50);
   endtask

   task automatic test_random_registers();
      for (int k = 0; k < 3; k++) begin
         load_camera($urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
         send_random(150);
      end
   endtask

   task automatic test_extreme_registers();
      load_camera(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                  32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
      send_random(200);
      load_camera(32'h0001_0000, 32'h0001_0000, 32'h0000_0000, 32'h0000_0000,
                  32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
      send_random(200);
      load_camera(32'h0100_0000, 32'h0080_0000, 32'h0200_0000, 32'h0100_0000,
                  32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
      send_random(100);
   endtask

   // ------------------------------------------------------------ receiver --
   always @(negedge clock) begin
      case ((cycle_count / 300) % 3)
         0:       rsp.ready <= 1'b1;
         1:       rsp.ready <= ($urandom_range(0, 9) < 7);
         default: rsp.ready <= ((cycle_count % 16) < 5);
      endcase
   end

   always @(posedge clock) begin
      cam_result_type exp_r;
      if (!reset && rsp.valid && rsp.ready) begin
         if (pending_results.size() == 0) begin
            $display("%0t: result with nothing expected: u=%0d v=%0d status=%0d",
                     $time, rsp.out_u, rsp.out_v, rsp.status);
            error_count++;
         end else begin
            exp_r = pending_results.pop_front();
            checked_count++;
            if (rsp.out_u !== exp_r.out_u)
               $display("%0t: out_u expected %0d actual %0d", $time, exp_r.out_u, rsp.out_u);
            if (rsp.out_v !== exp_r.out_v)
               $display("%0t: out_v expected %0d actual %0d", $time, exp_r.out_v, rsp.out_v);
            if (rsp.out_x !== exp_r.out_x)
               $display("%0t: out_x expected %h actual %h", $time, exp_r.out_x, rsp.out_x);
            if (rsp.out_y !== exp_r.out_y)
               $display("%0t: out_y expected %h actual %h", $time, exp_r.out_y, rsp.out_y);
            if (rsp.out_z !== exp_r.out_z)
               $display("%0t: out_z expected %h actual %h", $time, exp_r.out_z, rsp.out_z);
            if (rsp.status !== exp_r.status)
               $display("%0t: status expected %0d actual %0d", $time, exp_r.status, rsp.status);
            if (rsp.out_u !== exp_r.out_u || rsp.out_v !== exp_r.out_v ||
                rsp.out_x !== exp_r.out_x || rsp.out_y !== exp_r.out_y ||
                rsp.out_z !== exp_r.out_z || rsp.status !== exp_r.status)
               error_count++;
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Timed out with %0d results outstanding", pending_results.size());
         $display("Simulation FAILED");
         $finish;
      end
   end

   // ---------------------------------------------------------------- main --
   initial begin
      cycle_count = 0;
      error_count = 0;
      checked_count = 0;
      sent_count = 0;
      burst_left = 0;
      reset = 1'b1;
      req.valid = 1'b0;
      req.op = phdp_pkg::OP_PROJECT;
      req.pt_x = '0;
      req.pt_y = '0;
      req.pt_z = '0;
      req.pix_u = '0;
      req.pix_v = '0;
      req.flip_y = 1'b0;
      rsp.ready = 1'b0;
      csr.valid = 1'b0;
      csr.index = phdp_pkg::CSR_FOCAL_X;
      csr.data = '0;
      cam_regs[phdp_pkg::CSR_FOCAL_X]  = 32'h0001_0000;
      cam_regs[phdp_pkg::CSR_FOCAL_Y]  = 32'h0001_0000;
      cam_regs[phdp_pkg::CSR_CENTER_X] = 32'h0;
      cam_regs[phdp_pkg::CSR_CENTER_Y] = 32'h0;
      cam_regs[phdp_pkg::CSR_NORMAL_X] = 32'h0;
      cam_regs[phdp_pkg::CSR_NORMAL_Y] = 32'h0;
      cam_regs[phdp_pkg::CSR_NORMAL_Z] = 32'h0001_0000;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_directed_defaults();
      test_directed_special();
      test_random_camera();
      test_random_registers();
      test_extreme_registers();

      wait_drained();
      repeat (LATENCY + 10) @(posedge clock);
      $display("Sent %0d projection and back-projection items over twelve register settings,",
               sent_count);
      $display("checked %0d results with %0d mismatching.", checked_count, error_count);
      if (error_count == 0 && pending_results.size() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

@@ sim.f @@
rtl/core/phdp_pkg.sv
rtl/core/phdp_intf.sv
rtl/core/phdp_div_cell.sv
rtl/core/phdp_divider.sv
rtl/core/pinhole_project_deproject_top.sv
rtl/core/phdp_checker.sv
test/tb_top.sv
